// ===== hw/rtl/deq_pkg.sv =====
// Shared types and codes for the double-ended queue.
// Used by the controller, the datapath and the top level; no dependencies.
package deq_pkg;

    localparam int unsigned CAPACITY = 16;

    localparam int unsigned MODE_W   = 3;
    localparam int unsigned WORD_W   = 32;
    localparam int unsigned COUNT_W  = $clog2(CAPACITY + 1);
    localparam int unsigned STATUS_W = 2;

    localparam logic [MODE_W-1:0] MODE_PUSH_FRONT = 3'd0;
    localparam logic [MODE_W-1:0] MODE_PUSH_BACK  = 3'd1;
    localparam logic [MODE_W-1:0] MODE_POP_FRONT  = 3'd2;
    localparam logic [MODE_W-1:0] MODE_POP_BACK   = 3'd3;
    localparam logic [MODE_W-1:0] MODE_LOOK       = 3'd4;

    localparam logic [STATUS_W-1:0] STAT_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] STAT_EMPTY = 2'd1;
    localparam logic [STATUS_W-1:0] STAT_FULL  = 2'd2;

    typedef struct packed {
        logic [MODE_W-1:0] mode;
        logic [WORD_W-1:0] value;
    } deq_req_t;

    typedef struct packed {
        logic [WORD_W-1:0]   popped_value;
        logic [WORD_W-1:0]   front_value;
        logic [WORD_W-1:0]   back_value;
        logic [COUNT_W-1:0]  entry_count;
        logic [STATUS_W-1:0] status;
    } deq_res_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_FILL
    } deq_state_t;

    // Controller to datapath
    typedef struct packed {
        logic load;
        logic exec;
        logic fill;
    } deq_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic need_fill;
    } deq_stat_t;

endpackage

// ===== hw/rtl/double_ended_queue_top.sv =====
// Double-ended queue: a request is accepted at a clock edge with start high
// and busy low; its result strobes on done after the execute step, or after
// the refill step that reads the new end word from the RAM for a pop that
// leaves entries behind. A new request is taken only once the controller
// is idle again. rst_n clears indices and count (queue empty); RAM contents
// are not cleared. The receiver cannot stall: done is a one-cycle strobe.
module double_ended_queue_top #(
    parameter int unsigned DATA_WIDTH = 32
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  deq_pkg::deq_req_t request,
    output logic              done,
    output deq_pkg::deq_res_t result
);
    import deq_pkg::*;

    deq_cmd_t  cmd;
    deq_stat_t stat;

    deq_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .cmd   (cmd),
        .stat  (stat)
    );

    deq_datapath #(
        .DATA_WIDTH (DATA_WIDTH)
    ) u_datapath (
        .clk     (clk),
        .rst_n   (rst_n),
        .cmd     (cmd),
        .stat    (stat),
        .request (request),
        .done    (done),
        .result  (result)
    );

endmodule

// ===== hw/rtl/deq_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module deq_ram #(
    parameter int unsigned WIDTH = 32,
    parameter int unsigned DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== hw/rtl/deq_ctrl.sv =====
// Sequencer for the double-ended queue: accept, execute, optional refill.
// Depends on deq_pkg.
module deq_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    output deq_pkg::deq_cmd_t  cmd,
    input  deq_pkg::deq_stat_t stat
);
    import deq_pkg::*;

    deq_state_t state_reg;
    deq_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                // a pop that leaves entries must fetch the new end word
                state_next = stat.need_fill ? ST_FILL : ST_IDLE;
            end
            ST_FILL:
            begin
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd  = '0;
        busy = 1'b1;
        unique case (state_reg)
            ST_IDLE:
            begin
                busy     = 1'b0;
                cmd.load = start;
            end
            ST_EXEC:
            begin
                cmd.exec = 1'b1;
            end
            ST_FILL:
            begin
                cmd.fill = 1'b1;
            end
            default:
            begin
                busy = 1'b1;
            end
        endcase
    end

endmodule

// ===== hw/rtl/deq_datapath.sv =====
// Datapath of the double-ended queue: indices, count, cached end words,
// entry RAM and result register. Depends on deq_pkg and deq_ram.
module deq_datapath #(
    parameter int unsigned DATA_WIDTH = 32
) (
    input  logic               clk,
    input  logic               rst_n,
    input  deq_pkg::deq_cmd_t  cmd,
    output deq_pkg::deq_stat_t stat,
    input  deq_pkg::deq_req_t  request,
    output logic               done,
    output deq_pkg::deq_res_t  result
);
    import deq_pkg::*;

    localparam int unsigned AW = $clog2(CAPACITY);
    localparam int unsigned CW = $clog2(CAPACITY + 1);
    localparam logic [AW-1:0] LAST_SLOT = AW'(CAPACITY - 1);
    localparam logic [CW-1:0] FULL_CNT  = CW'(CAPACITY);
    localparam logic [CW-1:0] ONE_CNT   = CW'(1);

    function automatic logic [AW-1:0] slot_next(input logic [AW-1:0] i);
        return (i == LAST_SLOT) ? '0 : i + AW'(1);
    endfunction

    function automatic logic [AW-1:0] slot_prev(input logic [AW-1:0] i);
        return (i == '0) ? LAST_SLOT : i - AW'(1);
    endfunction

    deq_req_t              req_reg;
    logic [AW-1:0]         fidx_reg, fidx_next;
    logic [AW-1:0]         bidx_reg, bidx_next;
    logic [CW-1:0]         count_reg, count_next;
    logic [DATA_WIDTH-1:0] fval_reg, fval_next;
    logic [DATA_WIDTH-1:0] bval_reg, bval_next;
    logic [DATA_WIDTH-1:0] popped_reg, popped_next;
    logic [STATUS_W-1:0]   status_reg, status_next;
    deq_res_t              res_reg, res_next;
    logic                  done_reg, done_next;

    logic                  wr_en;
    logic [AW-1:0]         wr_addr;
    logic [DATA_WIDTH-1:0] word;
    logic                  rd_en;
    logic [AW-1:0]         rd_addr;
    logic [DATA_WIDTH-1:0] rd_data;
    logic                  is_pop;

    assign word   = DATA_WIDTH'(req_reg.value);
    assign is_pop = (req_reg.mode == MODE_POP_FRONT) || (req_reg.mode == MODE_POP_BACK);
    // pops leaving at least one entry need the new end word from the RAM
    assign stat.need_fill = is_pop && (count_reg > ONE_CNT);

    deq_ram #(
        .WIDTH (DATA_WIDTH),
        .DEPTH (CAPACITY)
    ) u_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (word),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            req_reg <= request;
        end
        fval_reg   <= fval_next;
        bval_reg   <= bval_next;
        popped_reg <= popped_next;
        status_reg <= status_next;
        res_reg    <= res_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fidx_reg  <= '0;
            bidx_reg  <= '0;
            count_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            fidx_reg  <= fidx_next;
            bidx_reg  <= bidx_next;
            count_reg <= count_next;
            done_reg  <= done_next;
        end
    end

    always_comb
    begin
        fidx_next   = fidx_reg;
        bidx_next   = bidx_reg;
        count_next  = count_reg;
        fval_next   = fval_reg;
        bval_next   = bval_reg;
        popped_next = popped_reg;
        status_next = status_reg;
        wr_en       = 1'b0;
        wr_addr     = bidx_reg;
        rd_en       = 1'b0;
        rd_addr     = slot_next(fidx_reg);

        if (cmd.exec)
        begin
            popped_next = '0;
            status_next = STAT_OK;
            case (req_reg.mode)
                MODE_PUSH_FRONT:
                begin
                    if (count_reg == FULL_CNT)
                    begin
                        status_next = STAT_FULL;
                    end
                    else
                    begin
                        fidx_next  = slot_prev(fidx_reg);
                        wr_en      = 1'b1;
                        wr_addr    = slot_prev(fidx_reg);
                        fval_next  = word;
                        count_next = count_reg + ONE_CNT;
                        if (count_reg == '0)
                        begin
                            bval_next = word;
                        end
                    end
                end
                MODE_PUSH_BACK:
                begin
                    if (count_reg == FULL_CNT)
                    begin
                        status_next = STAT_FULL;
                    end
                    else
                    begin
                        bidx_next  = slot_next(bidx_reg);
                        wr_en      = 1'b1;
                        wr_addr    = bidx_reg;
                        bval_next  = word;
                        count_next = count_reg + ONE_CNT;
                        if (count_reg == '0)
                        begin
                            fval_next = word;
                        end
                    end
                end
                MODE_POP_FRONT:
                begin
                    if (count_reg == '0)
                    begin
                        status_next = STAT_EMPTY;
                    end
                    else
                    begin
                        popped_next = fval_reg;
                        fidx_next   = slot_next(fidx_reg);
                        count_next  = count_reg - ONE_CNT;
                        rd_en       = stat.need_fill;
                        rd_addr     = slot_next(fidx_reg);
                    end
                end
                MODE_POP_BACK:
                begin
                    if (count_reg == '0)
                    begin
                        status_next = STAT_EMPTY;
                    end
                    else
                    begin
                        popped_next = bval_reg;
                        bidx_next   = slot_prev(bidx_reg);
                        count_next  = count_reg - ONE_CNT;
                        rd_en       = stat.need_fill;
                        rd_addr     = slot_prev(slot_prev(bidx_reg));
                    end
                end
                default:
                begin
                    status_next = STAT_OK;
                end
            endcase
        end

        if (cmd.fill)
        begin
            if (req_reg.mode == MODE_POP_FRONT)
            begin
                fval_next = rd_data;
            end
            else
            begin
                bval_next = rd_data;
            end
        end
    end

    always_comb
    begin
        done_next = (cmd.exec && !stat.need_fill) || cmd.fill;
        res_next  = res_reg;
        if (done_next)
        begin
            res_next.popped_value = WORD_W'(popped_next);
            res_next.front_value  = (count_next == '0) ? '0 : WORD_W'(fval_next);
            res_next.back_value   = (count_next == '0) ? '0 : WORD_W'(bval_next);
            res_next.entry_count  = COUNT_W'(count_next);
            res_next.status       = status_next;
        end
    end

    assign done   = done_reg;
    assign result = res_reg;

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= FULL_CNT)
        else $error("entry count above capacity");

    a_done_single: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |=> !done_reg)
        else $error("result strobe held for two cycles");

    a_full_status: assert property (@(posedge clk) disable iff (!rst_n)
        (done_reg && res_reg.status == STAT_FULL) |-> count_reg == FULL_CNT)
        else $error("full status while not full");

    a_empty_status: assert property (@(posedge clk) disable iff (!rst_n)
        (done_reg && res_reg.status == STAT_EMPTY) |-> count_reg == '0)
        else $error("empty status while entries held");

    a_fill_after_exec: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.fill |-> $past(cmd.exec) && $past(stat.need_fill))
        else $error("refill without a preceding pop");
`endif

endmodule
